// ===== hdl/tmh_pkg.sv =====
// Shared types, codes and defaults of the timer min-heap queue.
package tmh_pkg;

    localparam int CAPACITY_DEF  = 32;
    localparam int ID_SPACE_DEF  = 1024;
    localparam int TIME_BITS_DEF = 32;

    localparam int ACT_W = 3;
    localparam int ID_W  = 10;
    localparam int TMO_W = 20;
    localparam int REM_W = 20;
    localparam int STS_W = 2;

    localparam logic [REM_W-1:0] REM_MAX = {REM_W{1'b1}};

    localparam logic [ACT_W-1:0] ACT_TICK  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ADD   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ADJ   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_FIRE  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_QUERY = 3'd4;

    localparam logic [STS_W-1:0] STS_OK      = 2'd0;
    localparam logic [STS_W-1:0] STS_UNKNOWN = 2'd1;
    localparam logic [STS_W-1:0] STS_FULL    = 2'd2;

    localparam logic KIND_FIRED  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [ID_W-1:0]  timer_id;
        logic [TMO_W-1:0] timeout_ms;
    } req_t;

    typedef struct packed {
        logic             kind;
        logic [ID_W-1:0]  fired_id;
        logic [REM_W-1:0] remaining_ms;
        logic             heap_empty;
        logic [STS_W-1:0] status;
        logic             last;
    } rsp_t;

endpackage

// ===== hdl/tmh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tmh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/timer_min_heap.sv =====
// Timer queue: binary min-heap of expiry times with an id-to-slot map.
//
// Requests enter on req/req_valid and are taken when req_stall is low; each
// request yields one or more responses on rsp/rsp_valid, taken when rsp_stall
// is low. Every request ends with exactly one response with kind 1 and last 1;
// fire and query first give one kind 0 response per fired timer.
// One request is handled at a time: req_stall is high from acceptance until
// the final response has been loaded into the output register.
// The work of add, adjust and fire grows with each heap level climbed and
// each level sunk, all set by the single read port of the heap memory; a
// fired timer costs one remove (a climb and a sink) plus its delivery.
// Fired ids are buffered and sent after the heap work, so every response of
// a request carries the final heap_empty flag.
// Reset clears the clock counter and empties the heap; no memory is swept, a
// slot map entry counts only if its heap slot is live and owned by that id.
// A stalled receiver holds the sequencer in its delivery state; nothing drops.
module timer_min_heap #(
    parameter int CAPACITY  = tmh_pkg::CAPACITY_DEF,
    parameter int ID_SPACE  = tmh_pkg::ID_SPACE_DEF,
    parameter int TIME_BITS = tmh_pkg::TIME_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  tmh_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output tmh_pkg::rsp_t rsp
);

    import tmh_pkg::*;

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CW     = SLOT_W + 2;
    localparam int IDX_W  = $clog2(ID_SPACE);
    localparam int AW     = (IDX_W > ID_W) ? IDX_W : ID_W;
    localparam int HW     = TIME_BITS + ID_W;

    typedef enum logic [18:0] {
        ST_IDLE     = 19'h00001,
        ST_LOOK1    = 19'h00002,
        ST_LOOK2    = 19'h00004,
        ST_REMOVE   = 19'h00008,
        ST_REM_DAT  = 19'h00010,
        ST_UP       = 19'h00020,
        ST_UP_CMP   = 19'h00040,
        ST_AFTER_UP = 19'h00080,
        ST_LOAD_DN  = 19'h00100,
        ST_DOWN     = 19'h00200,
        ST_DN_L     = 19'h00400,
        ST_DN_R     = 19'h00800,
        ST_DN_CMP   = 19'h01000,
        ST_DONE     = 19'h02000,
        ST_QRY      = 19'h04000,
        ST_QRY_D    = 19'h08000,
        ST_DRAIN    = 19'h10000,
        ST_DR_WAIT  = 19'h20000,
        ST_FINAL    = 19'h40000
    } state_t;

    state_t state_reg, state_next;

    logic [ACT_W-1:0]     act_reg, act_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [TMO_W-1:0]     tmo_reg, tmo_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [SLOT_W-1:0]    i_reg, i_next;
    logic [SLOT_W-1:0]    start_reg, start_next;
    logic                 rem_mode_reg, rem_mode_next;
    logic [TIME_BITS-1:0] key_exp_reg, key_exp_next;
    logic [ID_W-1:0]      key_own_reg, key_own_next;
    logic [TIME_BITS-1:0] cand_exp_reg, cand_exp_next;
    logic [ID_W-1:0]      cand_own_reg, cand_own_next;
    logic [SLOT_W-1:0]    cidx_reg, cidx_next;
    logic [STS_W-1:0]     status_reg, status_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]     fcnt_reg, fcnt_next;
    logic [CNT_W-1:0]     fptr_reg, fptr_next;

    logic                 rsp_valid_reg;
    rsp_t                 rsp_reg, rsp_next;
    logic                 load;
    logic                 out_free;

    // memory ports
    logic                 put_en;
    logic [SLOT_W-1:0]    put_slot;
    logic [TIME_BITS-1:0] put_exp;
    logic [ID_W-1:0]      put_own;
    logic [SLOT_W-1:0]    h_raddr;
    logic [HW-1:0]        h_rdata;
    logic [AW-1:0]        own_ext;
    logic [AW-1:0]        id_ext;
    logic [SLOT_W-1:0]    s_rdata;
    logic                 f_we;
    logic [ID_W-1:0]      f_wdata;
    logic [ID_W-1:0]      f_rdata;

    logic [TIME_BITS-1:0] rd_exp;
    logic [ID_W-1:0]      rd_own;
    logic [SLOT_W-1:0]    up_p;
    logic [CW-1:0]        c_l;
    logic [CW-1:0]        c_r;
    logic [CW-1:0]        cnt_ext;
    logic [TIME_BITS-1:0] diff_due;
    logic [TIME_BITS-1:0] diff_up;
    logic [TIME_BITS-1:0] diff_lr;
    logic [TIME_BITS-1:0] diff_dn;
    logic [CNT_W-1:0]     last_slot;

    assign rd_exp   = h_rdata[HW-1:ID_W];
    assign rd_own   = h_rdata[ID_W-1:0];
    assign up_p     = SLOT_W'((i_reg - 1'b1) >> 1);
    assign c_l      = CW'({i_reg, 1'b1});
    assign c_r      = c_l + 1'b1;
    assign cnt_ext  = CW'(count_reg);
    assign diff_due = rd_exp - now_reg;
    assign diff_up  = key_exp_reg - rd_exp;
    assign diff_lr  = rd_exp - cand_exp_reg;
    assign diff_dn  = cand_exp_reg - key_exp_reg;
    assign last_slot = count_reg - 1'b1;
    assign own_ext  = AW'(put_own);
    // look the slot up as the request is taken, so it is ready in ST_LOOK1
    assign id_ext   = AW'(id_next);
    assign out_free = !rsp_valid_reg || !rsp_stall;

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    tmh_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_heap (
        .clk   (clk),
        .we    (put_en),
        .waddr (put_slot),
        .wdata ({put_exp, put_own}),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    tmh_ram #(.WIDTH(SLOT_W), .DEPTH(ID_SPACE)) u_slot (
        .clk   (clk),
        .we    (put_en),
        .waddr (own_ext[IDX_W-1:0]),
        .wdata (put_slot),
        .raddr (id_ext[IDX_W-1:0]),
        .rdata (s_rdata)
    );

    tmh_ram #(.WIDTH(ID_W), .DEPTH(CAPACITY)) u_fired (
        .clk   (clk),
        .we    (f_we),
        .waddr (fcnt_reg[SLOT_W-1:0]),
        .wdata (f_wdata),
        .raddr (fptr_reg[SLOT_W-1:0]),
        .rdata (f_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        act_next      = act_reg;
        id_next       = id_reg;
        tmo_next      = tmo_reg;
        now_next      = now_reg;
        count_next    = count_reg;
        i_next        = i_reg;
        start_next    = start_reg;
        rem_mode_next = rem_mode_reg;
        key_exp_next  = key_exp_reg;
        key_own_next  = key_own_reg;
        cand_exp_next = cand_exp_reg;
        cand_own_next = cand_own_reg;
        cidx_next     = cidx_reg;
        status_next   = status_reg;
        rem_next      = rem_reg;
        fcnt_next     = fcnt_reg;
        fptr_next     = fptr_reg;
        put_en        = 1'b0;
        put_slot      = i_reg;
        put_exp       = key_exp_reg;
        put_own       = key_own_reg;
        h_raddr       = '0;
        f_we          = 1'b0;
        f_wdata       = id_reg;
        load          = 1'b0;
        rsp_next      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    act_next    = req.action;
                    id_next     = req.timer_id;
                    tmo_next    = req.timeout_ms;
                    status_next = STS_OK;
                    rem_next    = '0;
                    fcnt_next   = '0;
                    fptr_next   = '0;
                    case (req.action)
                        ACT_TICK:
                        begin
                            now_next   = now_reg + 1'b1;
                            state_next = ST_DRAIN;
                        end
                        ACT_ADD, ACT_ADJ, ACT_FIRE:
                        begin
                            if (32'(req.timer_id) < ID_SPACE)
                            begin
                                state_next = ST_LOOK1;
                            end
                            else
                            begin
                                status_next = STS_UNKNOWN;
                                state_next  = ST_DRAIN;
                            end
                        end
                        ACT_QUERY:
                        begin
                            state_next = ST_QRY;
                        end
                        default:
                        begin
                            state_next = ST_DRAIN;
                        end
                    endcase
                end
            end
            ST_LOOK1:
            begin
                h_raddr    = s_rdata;
                i_next     = s_rdata;
                state_next = ST_LOOK2;
            end
            ST_LOOK2:
            begin
                // a map entry is live only if its slot is in use and owned by this id
                if ((CNT_W'(i_reg) < count_reg) && (rd_own == id_reg))
                begin
                    if (act_reg == ACT_FIRE)
                    begin
                        f_we       = 1'b1;
                        f_wdata    = id_reg;
                        fcnt_next  = fcnt_reg + 1'b1;
                        state_next = ST_REMOVE;
                    end
                    else
                    begin
                        key_exp_next  = now_reg + TIME_BITS'(tmo_reg);
                        key_own_next  = id_reg;
                        rem_mode_next = 1'b0;
                        state_next    = ST_UP;
                    end
                end
                else if (act_reg == ACT_ADD)
                begin
                    if (count_reg < CNT_W'(CAPACITY))
                    begin
                        i_next        = count_reg[SLOT_W-1:0];
                        count_next    = count_reg + 1'b1;
                        key_exp_next  = now_reg + TIME_BITS'(tmo_reg);
                        key_own_next  = id_reg;
                        rem_mode_next = 1'b0;
                        state_next    = ST_UP;
                    end
                    else
                    begin
                        status_next = STS_FULL;
                        state_next  = ST_DRAIN;
                    end
                end
                else
                begin
                    status_next = STS_UNKNOWN;
                    state_next  = ST_DRAIN;
                end
            end
            ST_REMOVE:
            begin
                count_next = last_slot;
                if (CNT_W'(i_reg) == last_slot)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    h_raddr       = last_slot[SLOT_W-1:0];
                    start_next    = i_reg;
                    rem_mode_next = 1'b1;
                    state_next    = ST_REM_DAT;
                end
            end
            ST_REM_DAT:
            begin
                key_exp_next = rd_exp;
                key_own_next = rd_own;
                state_next   = ST_UP;
            end
            ST_UP:
            begin
                if (i_reg == '0)
                begin
                    state_next = ST_AFTER_UP;
                end
                else
                begin
                    h_raddr    = up_p;
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP:
            begin
                if (diff_up[TIME_BITS-1])
                begin
                    // pull the parent down into the hole
                    put_en     = 1'b1;
                    put_exp    = rd_exp;
                    put_own    = rd_own;
                    i_next     = up_p;
                    state_next = ST_UP;
                end
                else
                begin
                    state_next = ST_AFTER_UP;
                end
            end
            ST_AFTER_UP:
            begin
                // after a remove the sink starts again at the vacated slot
                if (rem_mode_reg && (i_reg != start_reg))
                begin
                    put_en     = 1'b1;
                    i_next     = start_reg;
                    h_raddr    = start_reg;
                    state_next = ST_LOAD_DN;
                end
                else
                begin
                    state_next = ST_DOWN;
                end
            end
            ST_LOAD_DN:
            begin
                key_exp_next = rd_exp;
                key_own_next = rd_own;
                state_next   = ST_DOWN;
            end
            ST_DOWN:
            begin
                if (c_l >= cnt_ext)
                begin
                    put_en     = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    h_raddr    = c_l[SLOT_W-1:0];
                    state_next = ST_DN_L;
                end
            end
            ST_DN_L:
            begin
                cand_exp_next = rd_exp;
                cand_own_next = rd_own;
                cidx_next     = c_l[SLOT_W-1:0];
                if (c_r < cnt_ext)
                begin
                    h_raddr    = c_r[SLOT_W-1:0];
                    state_next = ST_DN_R;
                end
                else
                begin
                    state_next = ST_DN_CMP;
                end
            end
            ST_DN_R:
            begin
                // right child wins only when strictly earlier
                if (diff_lr[TIME_BITS-1])
                begin
                    cand_exp_next = rd_exp;
                    cand_own_next = rd_own;
                    cidx_next     = c_r[SLOT_W-1:0];
                end
                state_next = ST_DN_CMP;
            end
            ST_DN_CMP:
            begin
                put_en = 1'b1;
                if (diff_dn[TIME_BITS-1])
                begin
                    put_exp    = cand_exp_reg;
                    put_own    = cand_own_reg;
                    i_next     = cidx_reg;
                    state_next = ST_DOWN;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = (act_reg == ACT_QUERY) ? ST_QRY : ST_DRAIN;
            end
            ST_QRY:
            begin
                if (count_reg == '0)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    h_raddr    = '0;
                    state_next = ST_QRY_D;
                end
            end
            ST_QRY_D:
            begin
                if ((diff_due == '0) || diff_due[TIME_BITS-1])
                begin
                    f_we       = 1'b1;
                    f_wdata    = rd_own;
                    fcnt_next  = fcnt_reg + 1'b1;
                    i_next     = '0;
                    state_next = ST_REMOVE;
                end
                else
                begin
                    rem_next   = (diff_due > TIME_BITS'(REM_MAX)) ? REM_MAX
                                                                  : diff_due[REM_W-1:0];
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = (fptr_reg == fcnt_reg) ? ST_FINAL : ST_DR_WAIT;
            end
            ST_DR_WAIT:
            begin
                if (out_free)
                begin
                    load                = 1'b1;
                    rsp_next.kind       = KIND_FIRED;
                    rsp_next.fired_id   = f_rdata;
                    rsp_next.heap_empty = (count_reg == '0);
                    rsp_next.status     = STS_OK;
                    fptr_next           = fptr_reg + 1'b1;
                    state_next          = ST_DRAIN;
                end
            end
            ST_FINAL:
            begin
                if (out_free)
                begin
                    load                  = 1'b1;
                    rsp_next.kind         = KIND_STATUS;
                    rsp_next.remaining_ms = rem_reg;
                    rsp_next.heap_empty   = (count_reg == '0);
                    rsp_next.status       = status_reg;
                    rsp_next.last         = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            now_reg       <= '0;
            count_reg     <= '0;
            fcnt_reg      <= '0;
            fptr_reg      <= '0;
            rem_mode_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            now_reg      <= now_next;
            count_reg    <= count_next;
            fcnt_reg     <= fcnt_next;
            fptr_reg     <= fptr_next;
            rem_mode_reg <= rem_mode_next;
            if (load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        id_reg       <= id_next;
        tmo_reg      <= tmo_next;
        i_reg        <= i_next;
        start_reg    <= start_next;
        key_exp_reg  <= key_exp_next;
        key_own_reg  <= key_own_next;
        cand_exp_reg <= cand_exp_next;
        cand_own_reg <= cand_own_next;
        cidx_reg     <= cidx_next;
        status_reg   <= status_next;
        rem_reg      <= rem_next;
        if (load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("heap count above capacity");

    a_fired_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fcnt_reg <= CNT_W'(CAPACITY)) && (fptr_reg <= fcnt_reg))
        else $error("fired buffer pointers out of order");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg != ST_IDLE))
        else $error("request accepted without leaving idle");

    a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_reg.last == rsp_reg.kind))
        else $error("last flag disagrees with response kind");

endmodule
